FILE: rtl/cnt_pkg.sv
// Package with shared types, constants and codes for the Carmichael number test.
package cnt_pkg;

    localparam int NUM_BITS_DEFAULT = 32;

    typedef enum logic [2:0] {
        OUT_CARMICHAEL   = 3'd0,
        OUT_EVEN         = 3'd1,
        OUT_SQUARE       = 3'd2,
        OUT_KORSELT      = 3'd3,
        OUT_PRIME_OR_ONE = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        DIV_N_OVER_D = 2'd0,
        DIV_C_BY_D   = 2'd1,
        DIV_NM1_BY_P = 2'd2
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BOUND_GO,
        ST_BOUND_WAIT,
        ST_TRIAL_GO,
        ST_TRIAL_WAIT,
        ST_KORS_GO,
        ST_KORS_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_LAST_GO,
        ST_LAST_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load;        // load a new number
        logic     div_start;   // start the divider
        div_sel_t div_sel;     // divider operand selection
        logic     take_quot;   // cofactor <= quotient
        logic     step_div;    // trial divisor += 2
        logic     last_factor; // korselt operand is the cofactor
        logic     note;        // count one distinct factor
        logic     kors_check;  // latch korselt failure from remainder
        logic     set_one;     // distinct count = 1
        logic     finish;      // register the result
        outcome_t code;        // outcome to register on finish
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic n_odd;
        logic rem_zero;      // divider remainder is zero
        logic bound_ok;      // divisor <= quotient
        logic cof_gt1;
        logic cof_ne_n;
        logic count_ge2;
        logic kors_failed;
    } status_t;

endpackage

FILE: rtl/cnt_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module cnt_divider #(
    parameter int W = cnt_pkg::NUM_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quot_reg, quot_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[W-1]};
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next  = W'(trial - {1'b0, dvs_reg});
                quot_next = {quot_reg[W-2:0], 1'b1};
            end else begin
                rem_next  = trial[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;
endmodule

FILE: rtl/cnt_datapath.sv
// Datapath: number, cofactor, trial divisor, factor count, korselt flag and result.
module cnt_datapath #(
    parameter int W = cnt_pkg::NUM_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [W-1:0]      number,
    input  cnt_pkg::cmd_t     cmd,
    output cnt_pkg::status_t  status,
    output logic              is_carmichael,
    output logic [2:0]        outcome
);
    logic [W-1:0] n_reg, cof_reg, cof_next, d_reg, d_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic         kf_reg, kf_next;
    logic         isc_reg;
    logic [2:0]   out_reg;
    logic [W-1:0] dvd, dvs, quo, rem;
    logic         ddone;

    always_comb begin
        case (cmd.div_sel)
            cnt_pkg::DIV_N_OVER_D: begin dvd = cof_reg;  dvs = d_reg; end
            cnt_pkg::DIV_C_BY_D:   begin dvd = cof_reg;  dvs = d_reg; end
            cnt_pkg::DIV_NM1_BY_P: begin
                dvd = n_reg - 1'b1;
                dvs = (cmd.last_factor ? cof_reg : d_reg) - 1'b1;
            end
            default:               begin dvd = cof_reg;  dvs = d_reg; end
        endcase
    end

    cnt_divider #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(dvd), .divisor(dvs),
        .done(ddone), .quotient(quo), .remainder(rem)
    );

    always_comb begin
        cof_next = cof_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        kf_next  = kf_reg;
        if (cmd.load) begin
            cof_next = number;
            d_next   = W'(3);
            cnt_next = '0;
            kf_next  = 1'b0;
        end else begin
            if (cmd.take_quot) cof_next = quo;
            if (cmd.step_div)  d_next = d_reg + W'(2);
            if (cmd.note && cnt_reg != 4'd15) cnt_next = cnt_reg + 4'd1;
            if (cmd.set_one)   cnt_next = 4'd1;
            if (cmd.kors_check && rem != '0) kf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            n_reg   <= '0;
            cof_reg <= '0;
            d_reg   <= '0;
            cnt_reg <= '0;
            kf_reg  <= 1'b0;
            isc_reg <= 1'b0;
            out_reg <= 3'd0;
        end else begin
            if (cmd.load) n_reg <= number;
            cof_reg <= cof_next;
            d_reg   <= d_next;
            cnt_reg <= cnt_next;
            kf_reg  <= kf_next;
            if (cmd.finish) begin
                isc_reg <= (cmd.code == cnt_pkg::OUT_CARMICHAEL);
                out_reg <= cmd.code;
            end
        end
    end

    assign status.div_done    = ddone;
    assign status.n_odd       = n_reg[0];
    assign status.rem_zero    = (rem == '0);
    assign status.bound_ok    = (d_reg <= quo);
    assign status.cof_gt1     = (cof_reg > W'(1));
    assign status.cof_ne_n    = (cof_reg != n_reg);
    assign status.count_ge2   = (cnt_reg >= 4'd2);
    assign status.kors_failed = kf_reg;
    assign is_carmichael      = isc_reg;
    assign outcome            = out_reg;
endmodule

FILE: rtl/cnt_controller.sv
// Controller state machine sequencing trial division and the handshakes.
module cnt_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  cnt_pkg::status_t status,
    output cnt_pkg::cmd_t    cmd
);
    cnt_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) state_reg <= cnt_pkg::ST_IDLE;
        else        state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = cnt_pkg::OUT_CARMICHAEL;
        in_ready   = (state_reg == cnt_pkg::ST_IDLE) ||
                     (state_reg == cnt_pkg::ST_DONE && out_ready);
        out_valid  = (state_reg == cnt_pkg::ST_DONE);
        case (state_reg)
            cnt_pkg::ST_IDLE, cnt_pkg::ST_DONE: begin
                if (state_reg == cnt_pkg::ST_DONE && out_ready)
                    state_next = cnt_pkg::ST_IDLE;
                if (in_valid && in_ready) begin
                    cmd.load   = 1'b1;
                    state_next = cnt_pkg::ST_BOUND_GO;
                end
            end
            cnt_pkg::ST_BOUND_GO: begin
                if (!status.n_odd) begin
                    cmd.finish = 1'b1;
                    cmd.code   = cnt_pkg::OUT_EVEN;
                    state_next = cnt_pkg::ST_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = cnt_pkg::DIV_N_OVER_D;
                    state_next    = cnt_pkg::ST_BOUND_WAIT;
                end
            end
            cnt_pkg::ST_BOUND_WAIT: begin
                if (status.div_done) begin
                    // Same division also gives cofactor mod divisor.
                    if (!status.bound_ok) state_next = cnt_pkg::ST_LAST_GO;
                    else if (status.rem_zero) begin
                        cmd.take_quot = 1'b1;
                        cmd.note      = 1'b1;
                        state_next    = cnt_pkg::ST_KORS_GO;
                    end else begin
                        cmd.step_div = 1'b1;
                        state_next   = cnt_pkg::ST_BOUND_GO;
                    end
                end
            end
            cnt_pkg::ST_KORS_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = cnt_pkg::DIV_NM1_BY_P;
                state_next    = cnt_pkg::ST_KORS_WAIT;
            end
            cnt_pkg::ST_KORS_WAIT: begin
                cmd.div_sel = cnt_pkg::DIV_NM1_BY_P;
                if (status.div_done) begin
                    cmd.kors_check = 1'b1;
                    state_next     = cnt_pkg::ST_SQ_GO;
                end
            end
            cnt_pkg::ST_SQ_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = cnt_pkg::DIV_C_BY_D;
                state_next    = cnt_pkg::ST_SQ_WAIT;
            end
            cnt_pkg::ST_SQ_WAIT: begin
                if (status.div_done) begin
                    if (status.rem_zero) begin
                        cmd.finish = 1'b1;
                        cmd.code   = cnt_pkg::OUT_SQUARE;
                        state_next = cnt_pkg::ST_DONE;
                    end else begin
                        cmd.step_div = 1'b1;
                        state_next   = cnt_pkg::ST_BOUND_GO;
                    end
                end
            end
            cnt_pkg::ST_LAST_GO: begin
                if (status.cof_gt1 && status.cof_ne_n) begin
                    cmd.div_start   = 1'b1;
                    cmd.div_sel     = cnt_pkg::DIV_NM1_BY_P;
                    cmd.last_factor = 1'b1;
                    cmd.note        = 1'b1;
                    state_next      = cnt_pkg::ST_LAST_WAIT;
                end else begin
                    if (status.cof_gt1) cmd.set_one = 1'b1;
                    state_next = cnt_pkg::ST_LAST_WAIT;
                end
            end
            cnt_pkg::ST_LAST_WAIT: begin
                // Without a last factor no division runs; decide at once.
                if (status.div_done || !(status.cof_gt1 && status.cof_ne_n)) begin
                    cmd.kors_check = status.div_done;
                    cmd.finish     = 1'b1;
                    if (!status.count_ge2)
                        cmd.code = cnt_pkg::OUT_PRIME_OR_ONE;
                    else if (status.kors_failed || (status.div_done && !status.rem_zero))
                        cmd.code = cnt_pkg::OUT_KORSELT;
                    else
                        cmd.code = cnt_pkg::OUT_CARMICHAEL;
                    state_next = cnt_pkg::ST_DONE;
                end
            end
            default: state_next = cnt_pkg::ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/carmichael_number_test.sv
// Top level of the Carmichael number test by Korselt's criterion.
// One transaction in gives one transaction out: is_carmichael and an outcome code
// (0 Carmichael, 1 even, 2 square prime factor, 3 Korselt divisibility fails,
// 4 prime or one). The number is factored by odd trial division on a single shared
// restoring divider that yields one quotient bit per cycle. An even number is
// rejected in the first check state without any division; an odd number takes one
// division per trial divisor up to the square root of the remaining cofactor, plus
// a Korselt and a repeated-factor division for each prime factor found by trial
// division and a Korselt division for a last prime cofactor. One number is worked on
// at a time; the next transaction is taken in the same cycle the result is taken.
module carmichael_number_test #(
    parameter int NUM_BITS = cnt_pkg::NUM_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [NUM_BITS-1:0] number,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                is_carmichael,
    output logic [2:0]          outcome
);
    cnt_pkg::cmd_t    cmd;
    cnt_pkg::status_t status;

    // The controller sequences the bound, factor, Korselt and square checks.
    cnt_controller u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .cmd(cmd)
    );

    // The datapath holds the number, cofactor, divisor and result registers.
    cnt_datapath #(.W(NUM_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .number(number),
        .cmd(cmd), .status(status),
        .is_carmichael(is_carmichael), .outcome(outcome)
    );
endmodule

FILE: tb/carmichael_number_test_test.sv
// Testbench for the Carmichael number test: directed and random numbers checked against a predictor.
module carmichael_number_test_test;

    localparam int NB = 32;
    localparam longint CYCLE_LIMIT = 4000000;

    // Idle profiles: sender busy, receiver busy, or neither idling.
    typedef enum int {IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE} idle_mode_t;

    typedef struct {
        logic [NB-1:0]     num;
        bit                flag;
        cnt_pkg::outcome_t code;
    } verdict_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [NB-1:0] number;
    logic          out_valid;
    logic          out_ready;
    logic          is_carmichael;
    logic [2:0]    outcome;

    verdict_t   pending_verdicts[$];
    idle_mode_t idle_mode;
    int         error_count;
    longint     cycle_count;

    carmichael_number_test #(.NUM_BITS(NB)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .number(number),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .is_carmichael(is_carmichael),
        .outcome(outcome)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Korselt's criterion by odd trial division. A repeated prime ends the
    // search at once; a Korselt failure is only remembered, because a later
    // square factor still takes precedence over it.
    function automatic verdict_t korselt_verdict(input logic [NB-1:0] n);
        verdict_t       v;
        longint unsigned nv;
        longint unsigned cof;
        longint unsigned d;
        int              distinct;
        bit              failed;
        v.num  = n;
        v.flag = 1'b0;
        nv = n;
        cof = nv;
        d = 3;
        distinct = 0;
        failed = 1'b0;
        if (nv[0] == 1'b0)
        begin
            v.code = cnt_pkg::OUT_EVEN;
            return v;
        end
        while (d <= cof / d)
        begin
            if (cof % d == 0)
            begin
                cof = cof / d;
                if ((nv - 1) % (d - 1) != 0)
                    failed = 1'b1;
                distinct++;
                if (cof % d == 0)
                begin
                    v.code = cnt_pkg::OUT_SQUARE;
                    return v;
                end
            end
            d += 2;
        end
        // Whatever is left above one is the final prime factor.
        if (cof > 1 && cof != nv)
        begin
            if ((nv - 1) % (cof - 1) != 0)
                failed = 1'b1;
            distinct++;
        end
        else if (cof > 1)
            distinct = 1;
        if (distinct < 2)
            v.code = cnt_pkg::OUT_PRIME_OR_ONE;
        else if (failed)
            v.code = cnt_pkg::OUT_KORSELT;
        else
        begin
            v.code = cnt_pkg::OUT_CARMICHAEL;
            v.flag = 1'b1;
        end
        return v;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER_LIGHT: return $urandom_range(99) < 36;
            IDLE_SENDER_HEAVY: return $urandom_range(99) < 52;
            default:           return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idles();
        case (idle_mode)
            IDLE_SENDER_LIGHT: return $urandom_range(99) < 52;
            IDLE_SENDER_HEAVY: return $urandom_range(99) < 36;
            default:           return 1'b0;
        endcase
    endfunction

    // Present one number and hold it until the block takes the transaction.
    // Valid is lowered only when an idle gap follows, so it never drops and
    // rises again within one time step.
    task automatic send_number(input logic [NB-1:0] n);
        in_valid <= 1'b1;
        number   <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_verdicts.push_back(korselt_verdict(n));
        if (sender_idles())
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // The receiver throttles out_ready according to the current profile.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !receiver_idles();
    end

    // Every result transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result is_carmichael=%0d outcome=%0d",
                         $time, is_carmichael, outcome);
                error_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (is_carmichael !== want.flag)
                begin
                    $display("%0t: n=%0d is_carmichael expected %0d actual %0d",
                             $time, want.num, want.flag, is_carmichael);
                    error_count++;
                end
                if (outcome !== want.code)
                begin
                    $display("%0t: n=%0d outcome expected %0d actual %0d",
                             $time, want.num, want.code, outcome);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a hung block must not hang the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Zero, one, small and large primes, squares, Korselt failures, known
    // Carmichael numbers, and both extremes of the input range.
    task automatic test_directed();
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'd2);
        send_number(32'd3);
        send_number(32'd7);
        send_number(32'd9);
        send_number(32'd15);
        send_number(32'd45);
        // 75 fails Korselt at 5 before the square of 5 shows up.
        send_number(32'd75);
        send_number(32'd561);
        send_number(32'd1105);
        send_number(32'd1729);
        send_number(32'd8911);
        send_number(32'd65537);
        send_number(32'd340561);
        send_number(32'd3215031751);
        send_number(32'hFFFFFFFF);
        send_number(32'hFFFFFFFE);
        send_number(32'h80000000);
        send_number(32'd25 * 32'd171798691);
    endtask

    // Random numbers of shapes that finish in reasonable time: small
    // values, full-width even values, large multiples of 9 or 25 that stop on
    // a square, and known Carmichael numbers.
    task automatic test_random(input int count);
        logic [NB-1:0] carmichaels[12] = '{561, 1105, 1729, 2465, 2821, 6601,
                                           8911, 10585, 15841, 29341, 41041, 62745};
        logic [NB-1:0] n;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: n = $urandom_range(65535);
                4, 5:       n = $urandom() & 32'hFFFFFFFE;
                6:          n = 32'd9 * ($urandom_range(32'd477218587) | 32'd1);
                7:          n = 32'd25 * ($urandom_range(32'd171798690) | 32'd1);
                default:    n = carmichaels[$urandom_range(11)];
            endcase
            send_number(n);
        end
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        idle_mode   = IDLE_SENDER_LIGHT;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        number      = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(27);
        idle_mode = IDLE_SENDER_HEAVY;
        test_random(27);
        idle_mode = IDLE_NONE;
        test_random(27);
        in_valid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
